FILE: rtl/core/tsr_pkg.sv
// Shared types, constants and helper functions of the triangle span rasterizer.
package tsr_pkg;

    localparam int MAX_COLS  = 256;
    localparam int X_W       = 28;
    localparam int DIV_NUM_W = 28;
    localparam int DIV_DEN_W = 12;
    localparam int PROD_W    = 42;
    localparam int SUM_W     = 44;
    localparam int FRAC_W    = 16;

    localparam logic [1:0] REG_SURFACE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SURFACE_HEIGHT = 2'd1;

    localparam logic [8:0] SURFACE_WIDTH_RST  = 9'd64;
    localparam logic [6:0] SURFACE_HEIGHT_RST = 7'd64;

    localparam logic [1:0] VTX_A = 2'd0;
    localparam logic [1:0] VTX_B = 2'd1;
    localparam logic [1:0] VTX_C = 2'd2;

    localparam logic signed [SUM_W-1:0] X_HI = 44'sd134217727;
    localparam logic signed [SUM_W-1:0] X_LO = -44'sd134217728;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_L,
        ST_CHK_R,
        ST_DIV,
        ST_MUL,
        ST_FIN,
        ST_ROW,
        ST_MERGE,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } back_state_t;

    typedef struct packed {
        logic               mode;
        logic signed [10:0] vax;
        logic signed [10:0] vay;
        logic signed [10:0] vbx;
        logic signed [10:0] vby;
        logic signed [10:0] vcx;
        logic signed [10:0] vcy;
        logic [15:0]        color;
        logic [1:0]         lo;
        logic [9:0]         row_start;
    } cmd_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic [7:0]  left;
        logic [7:0]  right;
        logic [15:0] color;
    } span_data_t;

    function automatic logic signed [10:0] vtx_pick(
        input logic [1:0] sel,
        input logic signed [10:0] a,
        input logic signed [10:0] b,
        input logic signed [10:0] c
    );
        logic signed [10:0] r;
        case (sel)
            VTX_A:   r = a;
            VTX_B:   r = b;
            VTX_C:   r = c;
            default: r = a;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] vtx_prev(input logic [1:0] p);
        logic [1:0] r;
        case (p)
            VTX_A:   r = VTX_C;
            VTX_B:   r = VTX_A;
            VTX_C:   r = VTX_B;
            default: r = VTX_A;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] vtx_next(input logic [1:0] p);
        logic [1:0] r;
        case (p)
            VTX_A:   r = VTX_B;
            VTX_B:   r = VTX_C;
            VTX_C:   r = VTX_A;
            default: r = VTX_A;
        endcase
        return r;
    endfunction

    function automatic logic signed [X_W-1:0] sat_x(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > X_HI)
            r = X_HI;
        else if (v < X_LO)
            r = X_LO;
        else
            r = v;
        return r[X_W-1:0];
    endfunction

    // x / 65536 rounded toward zero
    function automatic logic signed [11:0] col_of(input logic signed [X_W-1:0] x);
        logic signed [11:0] q;
        q = x[X_W-1:FRAC_W];
        if (x[X_W-1] && (x[FRAC_W-1:0] != '0))
            q = q + 12'sd1;
        return q;
    endfunction

endpackage

FILE: rtl/core/tsr_front.sv
// Front end: accepts input words, finds the starting vertex and row, queues the command.
module tsr_front (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic signed [10:0] vertex_a_x,
    input  logic signed [10:0] vertex_a_y,
    input  logic signed [10:0] vertex_b_x,
    input  logic signed [10:0] vertex_b_y,
    input  logic signed [10:0] vertex_c_x,
    input  logic signed [10:0] vertex_c_y,
    input  logic [15:0]        fill_color,
    input  logic               fifo_full,
    output logic               push,
    output tsr_pkg::cmd_t      cmd
);

    logic [1:0]         lo;
    logic signed [10:0] lo_y;

    always_comb
    begin
        lo   = tsr_pkg::VTX_A;
        lo_y = vertex_a_y;
        if (vertex_b_y < lo_y)
        begin
            lo   = tsr_pkg::VTX_B;
            lo_y = vertex_b_y;
        end
        if (vertex_c_y < lo_y)
        begin
            lo   = tsr_pkg::VTX_C;
            lo_y = vertex_c_y;
        end
    end

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;

    always_comb
    begin
        cmd.mode      = mode;
        cmd.vax       = vertex_a_x;
        cmd.vay       = vertex_a_y;
        cmd.vbx       = vertex_b_x;
        cmd.vby       = vertex_b_y;
        cmd.vcx       = vertex_c_x;
        cmd.vcy       = vertex_c_y;
        cmd.color     = fill_color;
        cmd.lo        = lo;
        cmd.row_start = lo_y[10] ? 10'd0 : lo_y[9:0];
    end

endmodule

FILE: rtl/core/tsr_cmd_fifo.sv
// Two-entry command queue between front and back end.
module tsr_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tsr_pkg::cmd_t wdata,
    input  logic          pop,
    output tsr_pkg::cmd_t rdata,
    output logic          full,
    output logic          empty
);

    tsr_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

FILE: rtl/core/tsr_div.sv
// Restoring divider for edge slopes, one quotient bit per cycle.
module tsr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tsr_pkg::div_req_t req,
    output tsr_pkg::div_rsp_t rsp
);

    localparam int NW  = tsr_pkg::DIV_NUM_W;
    localparam int DW  = tsr_pkg::DIV_DEN_W;
    localparam int CNW = $clog2(NW + 1);

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CNW-1:0] cnt_reg;
    logic [CNW-1:0] cnt_next;
    logic [NW-1:0] q_reg;
    logic [NW-1:0] q_next;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] den_next;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, q_reg[NW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNW'(NW);
            q_next    = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            q_next   = {q_reg[NW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

FILE: rtl/core/tsr_back.sv
// Back end: edge walk, span merge into row tables, span emission.
module tsr_back #(
    parameter int MAX_ROWS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tsr_pkg::cmd_t cmd,
    input  logic          fifo_empty,
    output logic          pop,
    input  logic [8:0]    surface_width,
    input  logic [6:0]    surface_height,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [5:0]    span_row,
    output logic [7:0]    span_left,
    output logic [7:0]    span_right,
    output logic [15:0]   span_color,
    output logic          last_span
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int XW    = tsr_pkg::X_W;
    localparam int SW    = tsr_pkg::SUM_W;
    localparam int PW    = tsr_pkg::PROD_W;

    tsr_pkg::back_state_t state_reg;
    tsr_pkg::back_state_t state_next;

    tsr_pkg::cmd_t        cur_reg;
    logic signed [11:0]   row_reg;
    logic [1:0]           le_v_reg;
    logic [1:0]           re_v_reg;
    logic signed [11:0]   le_end_reg;
    logic signed [11:0]   re_end_reg;
    logic signed [XW-1:0] le_x_reg;
    logic signed [XW-1:0] re_x_reg;
    logic signed [XW-1:0] le_slope_reg;
    logic signed [XW-1:0] re_slope_reg;
    logic [1:0]           rem_reg;
    logic                 disp_flag_reg;

    logic                 adv_left_reg;
    logic [1:0]           adv_p_reg;
    logic [1:0]           adv_c_reg;
    logic                 adv_dxneg_reg;
    logic                 adv_dyz_reg;
    logic signed [XW-1:0] slope_reg;
    logic signed [PW-1:0] prod_reg;

    logic [7:0]           mg_b_reg;
    logic [7:0]           mg_e_reg;
    logic                 mg_ok_reg;
    logic [ROW_W-1:0]     mg_idx_reg;

    logic [MAX_ROWS-1:0]  act_vld_reg;
    logic [MAX_ROWS-1:0]  act_wide_reg;
    logic [MAX_ROWS-1:0]  disp_vld_reg;
    logic [MAX_ROWS-1:0]  disp_wide_reg;
    logic [MAX_ROWS-1:0]  emit_mask_reg;
    logic [ROW_W-1:0]     emit_row_reg;
    logic                 emit_sel_reg;

    logic                 out_valid_reg;
    logic [5:0]           out_row_reg;
    tsr_pkg::span_data_t  out_data_reg;
    logic                 out_last_reg;

    tsr_pkg::span_data_t  act_mem [MAX_ROWS];
    tsr_pkg::span_data_t  disp_mem [MAX_ROWS];
    tsr_pkg::span_data_t  act_rd_reg;
    tsr_pkg::span_data_t  disp_rd_reg;

    tsr_pkg::div_req_t    div_req;
    tsr_pkg::div_rsp_t    div_rsp;

    // control decodes
    logic                 adv_go_l;
    logic                 adv_go_r;
    logic                 row_go;
    logic                 out_free;
    logic                 act_re;
    logic [ROW_W-1:0]     act_raddr;
    logic                 disp_re;
    logic                 act_we;
    logic                 disp_we;
    logic                 out_load;
    logic                 emit_start_act;
    logic                 emit_start_disp;

    // datapath
    logic [6:0]           eff_h;
    logic signed [11:0]   eff_h_s;
    logic [8:0]           width_eff;
    logic signed [11:0]   wm1;
    logic [MAX_ROWS-1:0]  rowmask;
    logic [1:0]           iss_p;
    logic [1:0]           iss_c;
    logic signed [11:0]   dx_raw;
    logic signed [11:0]   dy_raw;
    logic signed [11:0]   dx_n;
    logic signed [11:0]   dy_n;
    logic signed [11:0]   dx_mag;
    logic signed [XW-1:0] slope_val;
    logic signed [10:0]   vx_p;
    logic signed [10:0]   vy_p;
    logic signed [10:0]   vy_c;
    logic signed [12:0]   mdiff;
    logic signed [13:0]   mfac;
    logic signed [SW-1:0] t_full;
    logic signed [SW-1:0] t_half;
    logic signed [XW-1:0] x_start;
    logic signed [11:0]   end_val;
    logic signed [11:0]   le_col;
    logic signed [11:0]   re_col;
    logic signed [11:0]   b_val;
    logic signed [11:0]   e_val;
    logic                 conflict;
    logic [7:0]           nl;
    logic [7:0]           nr;
    tsr_pkg::span_data_t  act_wdata;
    logic                 act_wwide;
    tsr_pkg::span_data_t  emit_data;
    logic [MAX_ROWS-1:0]  emit_bit;
    logic                 emit_last;

    tsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign eff_h     = (surface_height > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : surface_height;
    assign eff_h_s   = 12'(eff_h);
    assign width_eff = (surface_width > 9'(tsr_pkg::MAX_COLS)) ? 9'(tsr_pkg::MAX_COLS)
                                                                : surface_width;
    assign wm1       = 12'(width_eff) - 12'sd1;

    always_comb
    begin
        for (int i = 0; i < MAX_ROWS; i++)
            rowmask[i] = (7'(i) < eff_h);
    end

    // advance setup
    always_comb
    begin
        iss_p  = (state_reg == tsr_pkg::ST_CHK_L) ? le_v_reg : re_v_reg;
        iss_c  = (state_reg == tsr_pkg::ST_CHK_L) ? tsr_pkg::vtx_prev(iss_p)
                                                  : tsr_pkg::vtx_next(iss_p);
        dx_raw = 12'(tsr_pkg::vtx_pick(iss_c, cur_reg.vax, cur_reg.vbx, cur_reg.vcx))
               - 12'(tsr_pkg::vtx_pick(iss_p, cur_reg.vax, cur_reg.vbx, cur_reg.vcx));
        dy_raw = 12'(tsr_pkg::vtx_pick(iss_c, cur_reg.vay, cur_reg.vby, cur_reg.vcy))
               - 12'(tsr_pkg::vtx_pick(iss_p, cur_reg.vay, cur_reg.vby, cur_reg.vcy));
        dx_n   = dy_raw[11] ? -dx_raw : dx_raw;
        dy_n   = dy_raw[11] ? -dy_raw : dy_raw;
        dx_mag = dx_n[11] ? -dx_n : dx_n;
    end

    assign adv_go_l = (le_end_reg <= row_reg) && (rem_reg != 2'd0);
    assign adv_go_r = (re_end_reg <= row_reg) && (rem_reg != 2'd0);
    assign row_go   = (row_reg < le_end_reg) && (row_reg < re_end_reg);

    assign div_req.num   = {dx_mag[10:0], 17'd0} + tsr_pkg::DIV_NUM_W'(dy_n[10:0]);
    assign div_req.den   = {dy_n[10:0], 1'b0};
    assign div_req.start = ((state_reg == tsr_pkg::ST_CHK_L) && adv_go_l)
                        || ((state_reg == tsr_pkg::ST_CHK_R) && adv_go_r);

    assign slope_val = adv_dyz_reg ? '0
                     : (adv_dxneg_reg ? -$signed(div_rsp.quot) : $signed(div_rsp.quot));

    always_comb
    begin
        vx_p    = tsr_pkg::vtx_pick(adv_p_reg, cur_reg.vax, cur_reg.vbx, cur_reg.vcx);
        vy_p    = tsr_pkg::vtx_pick(adv_p_reg, cur_reg.vay, cur_reg.vby, cur_reg.vcy);
        vy_c    = tsr_pkg::vtx_pick(adv_c_reg, cur_reg.vay, cur_reg.vby, cur_reg.vcy);
        mdiff   = 13'(row_reg) - 13'(vy_p);
        mfac    = $signed({mdiff, 1'b1});
        t_full  = (SW'(vx_p) <<< 17) + SW'(prod_reg);
        t_half  = t_full >>> 1;
        x_start = tsr_pkg::sat_x(t_half);
        end_val = (12'(vy_c) < eff_h_s) ? 12'(vy_c) : eff_h_s;
    end

    // span columns
    always_comb
    begin
        le_col = tsr_pkg::col_of(le_x_reg);
        re_col = tsr_pkg::col_of(re_x_reg);
        b_val  = le_col[11] ? 12'sd0 : le_col;
        e_val  = (re_col < wm1) ? re_col : wm1;
    end

    // merge
    always_comb
    begin
        conflict = (act_rd_reg.color != cur_reg.color) || (mg_e_reg < act_rd_reg.left)
                || (mg_b_reg > act_rd_reg.right);
        nl       = (mg_b_reg < act_rd_reg.left) ? mg_b_reg : act_rd_reg.left;
        nr       = (mg_e_reg > act_rd_reg.right) ? mg_e_reg : act_rd_reg.right;
        act_wdata.color = cur_reg.color;
        if (act_vld_reg[mg_idx_reg] && !conflict)
        begin
            act_wdata.left  = nl;
            act_wdata.right = nr;
        end
        else
        begin
            act_wdata.left  = mg_b_reg;
            act_wdata.right = mg_e_reg;
        end
        act_wwide = (act_wdata.left < act_wdata.right);
    end

    assign emit_data = emit_sel_reg ? disp_rd_reg : act_rd_reg;
    assign emit_bit  = MAX_ROWS'(1) << emit_row_reg;
    assign emit_last = ((emit_mask_reg & ~emit_bit) == '0);
    assign out_free  = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsr_pkg::ST_IDLE:
                if (!fifo_empty)
                    state_next = cmd.mode ? tsr_pkg::ST_EMIT_RD : tsr_pkg::ST_CHK_L;
            tsr_pkg::ST_CHK_L:
                state_next = adv_go_l ? tsr_pkg::ST_DIV : tsr_pkg::ST_CHK_R;
            tsr_pkg::ST_CHK_R:
                state_next = adv_go_r ? tsr_pkg::ST_DIV : tsr_pkg::ST_ROW;
            tsr_pkg::ST_DIV:
                if (div_rsp.done)
                    state_next = tsr_pkg::ST_MUL;
            tsr_pkg::ST_MUL:
                state_next = tsr_pkg::ST_FIN;
            tsr_pkg::ST_FIN:
                state_next = adv_left_reg ? tsr_pkg::ST_CHK_L : tsr_pkg::ST_CHK_R;
            tsr_pkg::ST_ROW:
                if (row_go)
                    state_next = tsr_pkg::ST_MERGE;
                else if (rem_reg != 2'd0)
                    state_next = tsr_pkg::ST_CHK_L;
                else
                    state_next = disp_flag_reg ? tsr_pkg::ST_EMIT_RD : tsr_pkg::ST_IDLE;
            tsr_pkg::ST_MERGE:
                state_next = tsr_pkg::ST_ROW;
            tsr_pkg::ST_EMIT_RD:
                if (emit_mask_reg == '0)
                    state_next = tsr_pkg::ST_IDLE;
                else if (emit_mask_reg[emit_row_reg])
                    state_next = tsr_pkg::ST_EMIT_OUT;
            tsr_pkg::ST_EMIT_OUT:
                if (out_free)
                    state_next = tsr_pkg::ST_EMIT_RD;
            default:
                state_next = tsr_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop             = 1'b0;
        act_re          = 1'b0;
        act_raddr       = row_reg[ROW_W-1:0];
        disp_re         = 1'b0;
        act_we          = 1'b0;
        disp_we         = 1'b0;
        out_load        = 1'b0;
        emit_start_act  = 1'b0;
        emit_start_disp = 1'b0;
        case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                pop            = !fifo_empty;
                emit_start_act = !fifo_empty && cmd.mode;
            end
            tsr_pkg::ST_ROW:
            begin
                act_re          = row_go;
                emit_start_disp = !row_go && (rem_reg == 2'd0) && disp_flag_reg;
            end
            tsr_pkg::ST_MERGE:
            begin
                act_we  = mg_ok_reg;
                disp_we = mg_ok_reg && act_vld_reg[mg_idx_reg] && conflict;
            end
            tsr_pkg::ST_EMIT_RD:
            begin
                act_raddr = emit_row_reg;
                act_re    = (emit_mask_reg != '0) && emit_mask_reg[emit_row_reg];
                disp_re   = act_re;
            end
            tsr_pkg::ST_EMIT_OUT:
                out_load = out_free;
            default:
                pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsr_pkg::ST_IDLE;
            act_vld_reg   <= '0;
            disp_vld_reg  <= '0;
            emit_mask_reg <= '0;
            out_valid_reg <= 1'b0;
            rem_reg       <= 2'd0;
            disp_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tsr_pkg::ST_IDLE && !fifo_empty && !cmd.mode)
            begin
                rem_reg       <= 2'd3;
                disp_flag_reg <= 1'b0;
            end
            if (state_reg == tsr_pkg::ST_FIN)
                rem_reg <= rem_reg - 2'd1;
            if (act_we)
                act_vld_reg[mg_idx_reg] <= 1'b1;
            if (disp_we)
            begin
                disp_vld_reg[mg_idx_reg] <= 1'b1;
                disp_flag_reg            <= 1'b1;
            end
            if (emit_start_act)
            begin
                emit_mask_reg <= act_vld_reg & act_wide_reg & rowmask;
                act_vld_reg   <= act_vld_reg & ~rowmask;
            end
            if (emit_start_disp)
            begin
                emit_mask_reg <= disp_vld_reg & disp_wide_reg & rowmask;
                disp_vld_reg  <= disp_vld_reg & ~rowmask;
            end
            if (out_load)
                emit_mask_reg <= emit_mask_reg & ~emit_bit;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tsr_pkg::ST_IDLE && !fifo_empty)
        begin
            cur_reg    <= cmd;
            row_reg    <= 12'(cmd.row_start);
            le_v_reg   <= cmd.lo;
            re_v_reg   <= cmd.lo;
            le_end_reg <= 12'(cmd.row_start) - 12'sd1;
            re_end_reg <= 12'(cmd.row_start) - 12'sd1;
        end
        if (div_req.start)
        begin
            adv_left_reg  <= (state_reg == tsr_pkg::ST_CHK_L);
            adv_p_reg     <= iss_p;
            adv_c_reg     <= iss_c;
            adv_dxneg_reg <= dx_n[11];
            adv_dyz_reg   <= (dy_n == 12'sd0);
        end
        if (state_reg == tsr_pkg::ST_DIV && div_rsp.done)
            slope_reg <= slope_val;
        if (state_reg == tsr_pkg::ST_MUL)
            prod_reg <= slope_reg * mfac;
        if (state_reg == tsr_pkg::ST_FIN)
        begin
            if (adv_left_reg)
            begin
                le_v_reg     <= adv_c_reg;
                le_end_reg   <= end_val;
                le_slope_reg <= slope_reg;
                le_x_reg     <= x_start;
            end
            else
            begin
                re_v_reg     <= adv_c_reg;
                re_end_reg   <= end_val;
                re_slope_reg <= slope_reg;
                re_x_reg     <= x_start;
            end
        end
        if (state_reg == tsr_pkg::ST_ROW && row_go)
        begin
            mg_b_reg   <= b_val[7:0];
            mg_e_reg   <= e_val[7:0];
            mg_ok_reg  <= (b_val <= e_val);
            mg_idx_reg <= row_reg[ROW_W-1:0];
            row_reg    <= row_reg + 12'sd1;
            le_x_reg   <= tsr_pkg::sat_x(SW'(le_x_reg) + SW'(le_slope_reg));
            re_x_reg   <= tsr_pkg::sat_x(SW'(re_x_reg) + SW'(re_slope_reg));
        end
        if (act_we)
            act_wide_reg[mg_idx_reg] <= act_wwide;
        if (disp_we)
            disp_wide_reg[mg_idx_reg] <= act_wide_reg[mg_idx_reg];
        if (emit_start_act || emit_start_disp)
        begin
            emit_row_reg <= '0;
            emit_sel_reg <= emit_start_disp;
        end
        if (state_reg == tsr_pkg::ST_EMIT_RD && !act_re && emit_mask_reg != '0)
            emit_row_reg <= emit_row_reg + 1'b1;
        if (out_load)
        begin
            emit_row_reg <= emit_row_reg + 1'b1;
            out_row_reg  <= 6'(emit_row_reg);
            out_data_reg <= emit_data;
            out_last_reg <= emit_last;
        end
    end

    // row tables
    always_ff @(posedge clk)
    begin
        if (act_we)
            act_mem[mg_idx_reg] <= act_wdata;
        if (act_re)
            act_rd_reg <= act_mem[act_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (disp_we)
            disp_mem[mg_idx_reg] <= act_rd_reg;
        if (disp_re)
            disp_rd_reg <= disp_mem[emit_row_reg];
    end

    assign out_valid  = out_valid_reg;
    assign span_row   = out_row_reg;
    assign span_left  = out_data_reg.left;
    assign span_right = out_data_reg.right;
    assign span_color = out_data_reg.color;
    assign last_span  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_emit_row_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tsr_pkg::ST_EMIT_OUT |-> emit_mask_reg[emit_row_reg])
        else $error("emitting a row that is not flagged");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == tsr_pkg::ST_DIV)
        else $error("divider finished outside slope wait");

    a_merge_after_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tsr_pkg::ST_MERGE |-> $past(state_reg) == tsr_pkg::ST_ROW)
        else $error("merge without a row read");

    a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && emit_last |=> emit_mask_reg == '0)
        else $error("spans left after last word");
`endif

endmodule

FILE: rtl/core/triangle_span_rasterizer_core.sv
// Top level of the triangle span rasterizer: configuration registers, front, queue, back.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | mode, vertex_{a,b,c}_{x,y}, fill_color
//  out     | out_valid/out_ready  | span_row, span_left, span_right, span_color, last_span
//
// Flush: the flagged rows below the height are scanned and their spans emitted in row order.
// Triangle: each edge setup waits on the slope divider (3 setups at most), each covered row
// is read and merged into the row tables, then displaced spans drain as for a flush.
// Reset clears all row valid flags at once; there is no clearing pass.
// A stalled out channel holds the back end; the front keeps taking up to two words.
module triangle_span_rasterizer_core #(
    parameter int MAX_ROWS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic signed [10:0] vertex_a_x,
    input  logic signed [10:0] vertex_a_y,
    input  logic signed [10:0] vertex_b_x,
    input  logic signed [10:0] vertex_b_y,
    input  logic signed [10:0] vertex_c_x,
    input  logic signed [10:0] vertex_c_y,
    input  logic [15:0]        fill_color,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         span_row,
    output logic [7:0]         span_left,
    output logic [7:0]         span_right,
    output logic [15:0]        span_color,
    output logic               last_span
);

    logic [8:0]    surf_w_reg;
    logic [6:0]    surf_h_reg;
    logic          fifo_push;
    logic          fifo_pop;
    logic          fifo_full;
    logic          fifo_empty;
    tsr_pkg::cmd_t front_cmd;
    tsr_pkg::cmd_t queue_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surf_w_reg <= tsr_pkg::SURFACE_WIDTH_RST;
            surf_h_reg <= tsr_pkg::SURFACE_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tsr_pkg::REG_SURFACE_WIDTH:  surf_w_reg <= cfg_data;
                tsr_pkg::REG_SURFACE_HEIGHT: surf_h_reg <= cfg_data[6:0];
                default:                     surf_w_reg <= surf_w_reg;
            endcase
        end
    end

    tsr_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .vertex_a_x (vertex_a_x),
        .vertex_a_y (vertex_a_y),
        .vertex_b_x (vertex_b_x),
        .vertex_b_y (vertex_b_y),
        .vertex_c_x (vertex_c_x),
        .vertex_c_y (vertex_c_y),
        .fill_color (fill_color),
        .fifo_full  (fifo_full),
        .push       (fifo_push),
        .cmd        (front_cmd)
    );

    tsr_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .wdata (front_cmd),
        .pop   (fifo_pop),
        .rdata (queue_cmd),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    tsr_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (queue_cmd),
        .fifo_empty     (fifo_empty),
        .pop            (fifo_pop),
        .surface_width  (surf_w_reg),
        .surface_height (surf_h_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .span_row       (span_row),
        .span_left      (span_left),
        .span_right     (span_right),
        .span_color     (span_color),
        .last_span      (last_span)
    );

endmodule
